// ===== sv/wdc_pkg.sv =====
// Shared types, constants and calendar helpers for the working day counter.
// Used by wdc_weekday, wdc_walker and working_day_counter; depends on nothing.
package wdc_pkg;

  localparam int unsigned MaxSpanDefault = 32767;
  localparam logic [6:0]  WeekendMaskReset = 7'd96;
  localparam logic [14:0] CountMax = 15'h7FFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_NO_REACH = 2'd2
  } wdc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WD_START,
    S_WD_END,
    S_WD_CAP_START,
    S_WD_CAP_END,
    S_WALK
  } wdc_state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } wdc_walk_ctrl_t;

  // x / 100 by reciprocal, exact for x below 43699
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] prod;
    prod = {13'd0, x} * 27'd5243;
    return prod[26:19];
  endfunction

  // y % 400 == 0, or y % 4 == 0 and y % 100 != 0
  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0]  q;
    logic [13:0] hund;
    logic [13:0] r;
    q    = div100(y);
    hund = {q[7:0], 6'd0} + {1'b0, q[7:0], 5'd0} + {4'd0, q[7:0], 2'd0};
    r    = y - hund;
    return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // (31 * mm) / 12 for mm in 1..12
  function automatic logic [4:0] month_term(input logic [3:0] mm);
    logic [4:0] t;
    case (mm)
      4'd1:    t = 5'd2;
      4'd2:    t = 5'd5;
      4'd3:    t = 5'd7;
      4'd4:    t = 5'd10;
      4'd5:    t = 5'd12;
      4'd6:    t = 5'd15;
      4'd7:    t = 5'd18;
      4'd8:    t = 5'd20;
      4'd9:    t = 5'd23;
      4'd10:   t = 5'd25;
      4'd11:   t = 5'd28;
      4'd12:   t = 5'd31;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // x mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [13:0] x);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = {3'd0, x[13:12]} + {2'd0, x[11:9]} + {2'd0, x[8:6]} + {2'd0, x[5:3]}
       + {2'd0, x[2:0]};
    f2 = {2'd0, f1[4:3]} + {1'b0, f1[2:0]};
    return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
  endfunction

endpackage

// ===== sv/wdc_weekday.sv =====
// Two-stage weekday unit: date in, weekday (0 Sunday) out of the second register stage.
// Depends on wdc_pkg for the reciprocal divide, month table and mod 7.
module wdc_weekday (
  input  logic        clk,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  output logic [2:0]  weekday
);

  logic        early;
  logic [3:0]  mm;
  logic [13:0] yy;
  logic [13:0] sum1;
  logic [7:0]  cent;
  logic [13:0] sum1_next;
  logic [7:0]  cent_next;
  logic [13:0] net;

  // January and February count as months 11 and 12 of the previous year
  always_comb begin
    early     = (month < 4'd3);
    mm        = early ? (month + 4'd10) : (month - 4'd2);
    yy        = year - {13'd0, early};
    cent_next = wdc_pkg::div100(yy);
    sum1_next = {9'd0, day} + yy + {2'd0, yy[13:2]} + {8'd0, cent_next[7:2]}
              + {9'd0, wdc_pkg::month_term(mm)};
  end

  always_ff @(posedge clk) begin
    sum1 <= sum1_next;
    cent <= cent_next;
  end

  assign net = sum1 - {6'd0, cent};

  always_ff @(posedge clk) begin
    weekday <= wdc_pkg::mod7(net);
  end

endmodule

// ===== sv/wdc_walker.sv =====
// Date stepper: advance one calendar day per cycle while ctrl.advance is high, with month and year rollover.
// Depends on wdc_pkg for days_in, is_leap and the control struct.
module wdc_walker (
  input  logic                    clk,
  input  wdc_pkg::wdc_walk_ctrl_t ctrl,
  input  logic [4:0]              ld_day,
  input  logic [3:0]              ld_month,
  input  logic [13:0]             ld_year,
  output logic [4:0]              day,
  output logic [3:0]              month,
  output logic [13:0]             year
);

  logic       leap;
  logic [4:0] dim;

  assign dim = wdc_pkg::days_in(month, leap);

  // leap is registered from year, so it trails a year change; February is weeks away by then
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      day   <= ld_day;
      month <= ld_month;
      year  <= ld_year;
      leap  <= wdc_pkg::is_leap(ld_year);
    end else begin
      leap <= wdc_pkg::is_leap(year);
      if (ctrl.advance) begin
        if (day == dim) begin
          day <= 5'd1;
          if (month == 4'd12) begin
            month <= 4'd1;
            year  <= year + 14'd1;
          end else begin
            month <= month + 4'd1;
          end
        end else begin
          day <= day + 5'd1;
        end
      end
    end
  end

endmodule

// ===== sv/working_day_counter.sv =====
// Working day counter over Gregorian dates.
// Command channel: present both dates and raise start while busy is low; the
// dates are latched on that edge and busy stays high until the result beat.
// The result (working_days, start_weekday, end_weekday, status) is on the
// ports for exactly one cycle, marked by done; the receiver cannot stall it.
// Config channel: cfg_data (weekend mask, bit n = weekday n is off) is written
// when cfg_valid and cfg_ready are high; write it only while the block is idle.
// Sequence: a validity check of both dates; an invalid date ends there with
// the result. Otherwise the start and then the end date pass through the
// two-stage weekday unit, then the date walker advances one day per cycle
// until the end date is met or MAX_SPAN days have been walked, and the
// result beat follows once the stop is seen.
// Busy drops in the result cycle, so the next start is taken then; no new
// command is taken while one is in progress.
// Reset: synchronous, active high; returns to idle, mask to Friday+Saturday.
// An end before the start runs MAX_SPAN steps and reports status 2.
module working_day_counter #(
  parameter int unsigned MAX_SPAN = wdc_pkg::MaxSpanDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [13:0] start_year,
  input  logic [4:0]  end_day,
  input  logic [3:0]  end_month,
  input  logic [13:0] end_year,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [14:0] working_days,
  output logic [2:0]  start_weekday,
  output logic [2:0]  end_weekday,
  output logic [1:0]  status
);

  localparam int unsigned SpanW = $clog2(MAX_SPAN + 1);

  wdc_pkg::wdc_state_t     state, state_next;
  wdc_pkg::wdc_walk_ctrl_t walk_ctrl;

  logic [6:0]       weekend_mask;
  logic [4:0]       sd, ed;
  logic [3:0]       sm, em;
  logic [13:0]      sy, ey;
  logic [2:0]       swd, ewd, wd, wd_inc, wd_res;
  logic [SpanW-1:0] steps;
  logic [14:0]      count;
  logic             sel_end;
  logic [4:0]       wk_day, wu_day;
  logic [3:0]       wk_month, wu_month;
  logic [13:0]      wk_year, wu_year;
  logic             dates_ok, reached, span_out, stepping;

  // Validity of both latched dates
  always_comb begin
    dates_ok = (sy >= 14'd1) && (sy <= 14'd9999) && (ey >= 14'd1) && (ey <= 14'd9999)
             && (sd >= 5'd1) && (sd <= wdc_pkg::days_in(sm, wdc_pkg::is_leap(sy)))
             && (ed >= 5'd1) && (ed <= wdc_pkg::days_in(em, wdc_pkg::is_leap(ey)));
  end

  assign reached  = (wk_day == ed) && (wk_month == em) && (wk_year == ey);
  assign span_out = (steps == SpanW'(MAX_SPAN));
  assign wd_inc   = (wd == 3'd6) ? 3'd0 : (wd + 3'd1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wdc_pkg::S_IDLE:         if (start) state_next = wdc_pkg::S_CHECK;
      wdc_pkg::S_CHECK:        state_next = dates_ok ? wdc_pkg::S_WD_START : wdc_pkg::S_IDLE;
      wdc_pkg::S_WD_START:     state_next = wdc_pkg::S_WD_END;
      wdc_pkg::S_WD_END:       state_next = wdc_pkg::S_WD_CAP_START;
      wdc_pkg::S_WD_CAP_START: state_next = wdc_pkg::S_WD_CAP_END;
      wdc_pkg::S_WD_CAP_END:   state_next = wdc_pkg::S_WALK;
      wdc_pkg::S_WALK:         if (reached || span_out) state_next = wdc_pkg::S_IDLE;
      default:                 state_next = wdc_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    walk_ctrl = '0;
    sel_end   = 1'b0;
    stepping  = 1'b0;
    unique case (state)
      wdc_pkg::S_CHECK:  walk_ctrl.load = 1'b1;
      wdc_pkg::S_WD_END: sel_end = 1'b1;
      wdc_pkg::S_WALK: begin
        stepping          = !reached && !span_out;
        walk_ctrl.advance = stepping;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state != wdc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weekend_mask <= wdc_pkg::WeekendMaskReset;
    end else if (cfg_valid && cfg_ready) begin
      weekend_mask <= cfg_data;
    end
  end

  // Latch the command beat
  always_ff @(posedge clk) begin
    if (state == wdc_pkg::S_IDLE && start) begin
      sd <= start_day;
      sm <= start_month;
      sy <= start_year;
      ed <= end_day;
      em <= end_month;
      ey <= end_year;
    end
  end

  // Weekday unit input: start date, then end date
  assign wu_day   = sel_end ? ed : sd;
  assign wu_month = sel_end ? em : sm;
  assign wu_year  = sel_end ? ey : sy;

  wdc_weekday u_weekday (
    .clk     (clk),
    .day     (wu_day),
    .month   (wu_month),
    .year    (wu_year),
    .weekday (wd_res)
  );

  wdc_walker u_walker (
    .clk      (clk),
    .ctrl     (walk_ctrl),
    .ld_day   (sd),
    .ld_month (sm),
    .ld_year  (sy),
    .day      (wk_day),
    .month    (wk_month),
    .year     (wk_year)
  );

  // Weekday capture, walk counters
  always_ff @(posedge clk) begin
    if (state == wdc_pkg::S_CHECK) begin
      steps <= '0;
      count <= '0;
    end
    if (state == wdc_pkg::S_WD_CAP_START) begin
      swd <= wd_res;
    end
    if (state == wdc_pkg::S_WD_CAP_END) begin
      ewd <= wd_res;
      wd  <= swd;
    end
    if (stepping) begin
      wd    <= wd_inc;
      steps <= steps + SpanW'(1);
      // count the day unless masked; hold at the top
      if (!weekend_mask[wd_inc] && count != wdc_pkg::CountMax) begin
        count <= count + 15'd1;
      end
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == wdc_pkg::S_CHECK) && !dates_ok)
           || ((state == wdc_pkg::S_WALK) && (reached || span_out));
    end
  end

  always_ff @(posedge clk) begin
    if (state == wdc_pkg::S_CHECK && !dates_ok) begin
      working_days  <= '0;
      start_weekday <= '0;
      end_weekday   <= '0;
      status        <= wdc_pkg::ST_BAD_DATE;
    end else if (state == wdc_pkg::S_WALK && (reached || span_out)) begin
      start_weekday <= swd;
      end_weekday   <= ewd;
      if (reached) begin
        working_days <= count;
        status       <= wdc_pkg::ST_OK;
      end else begin
        working_days <= '0;
        status       <= wdc_pkg::ST_NO_REACH;
      end
    end
  end

`ifndef SYNTH
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == wdc_pkg::S_CHECK || $past(state) == wdc_pkg::S_WALK))
    else $error("result beat without a finishing state");

  a_busy_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == wdc_pkg::ST_BAD_DATE) |->
      (working_days == '0 && start_weekday == '0 && end_weekday == '0))
    else $error("invalid date result carries nonzero fields");

  a_span_bound: assert property (@(posedge clk) disable iff (rst)
    (state == wdc_pkg::S_WALK) |-> (steps <= SpanW'(MAX_SPAN)))
    else $error("walk ran past the span limit");
`endif

endmodule
